[hw/rtl/assert_macros.svh]
// Assertion macros used by the chunk allocator sequencer, ffca_ctrl.
// Depends on nothing; every macro assumes clk_i and rst_ni are in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[hw/rtl/ffca_pkg.sv]
// Types and constants for the first-fit chunk allocator.
// Depends on nothing; used by ffca_ctrl and first_fit_chunk_allocator.
package ffca_pkg;

  localparam int unsigned CountW      = 10;
  localparam int unsigned StatusW     = 2;
  localparam logic [CountW-1:0] ChunkSizeRst = 10'd10;

  // Input op codes.
  localparam logic OpAlloc = 1'b0;
  localparam logic OpClear = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 2'd0,
    STAT_TOO_BIG = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_CLEARED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CLEAR
  } state_e;

  // One chunk table entry as held in the RAM.
  typedef struct packed {
    logic [CountW-1:0] cap;
    logic [CountW-1:0] used;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

[hw/rtl/ffca_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module ffca_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/ffca_ctrl.sv]
// Sequencer of the chunk allocator: first-fit scan over the chunk RAM, append,
// clear. Depends on ffca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffca_ctrl #(
  parameter int unsigned MAX_CHUNKS = 64,
  localparam int unsigned IdxW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
  localparam int unsigned NumW = $clog2(MAX_CHUNKS + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request side
  input  logic                             req_valid_i,
  input  logic                             req_op_i,
  input  logic [ffca_pkg::CountW-1:0]      req_count_i,
  output logic                             req_ready_o,
  input  logic [ffca_pkg::CountW-1:0]      new_cap_i,
  // Result side
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output ffca_pkg::status_e                res_status_o,
  output logic [IdxW-1:0]                  res_idx_o,
  output logic [ffca_pkg::CountW-1:0]      res_off_o,
  // Chunk RAM
  output logic                             ram_rd_en_o,
  output logic [IdxW-1:0]                  ram_rd_addr_o,
  input  ffca_pkg::entry_t                 ram_rd_data_i,
  output logic                             ram_wr_en_o,
  output logic [IdxW-1:0]                  ram_wr_addr_o,
  output ffca_pkg::entry_t                 ram_wr_data_o
);

  ffca_pkg::state_e              state_q, state_d;
  logic [NumW-1:0]               num_q, num_d;
  logic [IdxW-1:0]               idx_q, idx_d;
  logic [ffca_pkg::CountW-1:0]   count_q, count_d;

  logic                          fits;
  logic                          last;
  logic [ffca_pkg::CountW:0]     free_space;

  // Free space of the entry just read; a used count above the capacity never fits.
  assign free_space = {1'b0, ram_rd_data_i.cap} - {1'b0, ram_rd_data_i.used};
  assign fits = (ram_rd_data_i.cap >= ram_rd_data_i.used) &&
                (free_space[ffca_pkg::CountW-1:0] >= count_q);
  assign last = (NumW'(idx_q) == (num_q - NumW'(1)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffca_pkg::S_IDLE: begin
        if (req_valid_i) begin
          if (req_op_i == ffca_pkg::OpClear) begin
            state_d = ffca_pkg::S_CLEAR;
          end else if (num_q == '0) begin
            state_d = ffca_pkg::S_DECIDE;
          end else begin
            state_d = ffca_pkg::S_SCAN;
          end
        end
      end
      ffca_pkg::S_SCAN: begin
        if (fits) begin
          if (res_ready_i) begin
            state_d = ffca_pkg::S_IDLE;
          end
        end else if (last) begin
          state_d = ffca_pkg::S_DECIDE;
        end
      end
      ffca_pkg::S_DECIDE, ffca_pkg::S_CLEAR: begin
        if (res_ready_i) begin
          state_d = ffca_pkg::S_IDLE;
        end
      end
      default: state_d = ffca_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    res_valid_o   = 1'b0;
    res_status_o  = ffca_pkg::STAT_OK;
    res_idx_o     = '0;
    res_off_o     = '0;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = idx_q;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = idx_q;
    ram_wr_data_o = ram_rd_data_i;
    num_d         = num_q;
    idx_d         = idx_q;
    count_d       = count_q;
    unique case (state_q)
      ffca_pkg::S_IDLE: begin
        req_ready_o   = 1'b1;
        ram_rd_en_o   = req_valid_i;
        ram_rd_addr_o = '0;
        if (req_valid_i) begin
          count_d = req_count_i;
          idx_d   = '0;
        end
      end
      ffca_pkg::S_SCAN: begin
        ram_rd_en_o = 1'b1;
        if (fits) begin
          // Hold the read address while the result waits, so the entry stays put.
          res_valid_o        = 1'b1;
          res_idx_o          = idx_q;
          res_off_o          = ram_rd_data_i.used;
          ram_wr_en_o        = res_ready_i;
          ram_wr_data_o.used = ram_rd_data_i.used + count_q;
        end else if (!last) begin
          idx_d         = idx_q + IdxW'(1);
          ram_rd_addr_o = idx_q + IdxW'(1);
        end
      end
      ffca_pkg::S_DECIDE: begin
        res_valid_o   = 1'b1;
        ram_wr_addr_o = IdxW'(num_q);
        ram_wr_data_o = '{cap: new_cap_i, used: count_q};
        if (count_q > new_cap_i) begin
          res_status_o = ffca_pkg::STAT_TOO_BIG;
        end else if (num_q == NumW'(MAX_CHUNKS)) begin
          res_status_o = ffca_pkg::STAT_FULL;
        end else begin
          res_idx_o   = IdxW'(num_q);
          ram_wr_en_o = res_ready_i;
          if (res_ready_i) begin
            num_d = num_q + NumW'(1);
          end
        end
      end
      ffca_pkg::S_CLEAR: begin
        res_valid_o  = 1'b1;
        res_status_o = ffca_pkg::STAT_CLEARED;
        if (res_ready_i) begin
          num_d = '0;
        end
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffca_pkg::S_IDLE;
      num_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      num_q   <= num_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  `ASSERT_PROP(a_wr_res, ram_wr_en_o |-> (res_valid_o && res_ready_i), "write without result")
  `ASSERT_NEVER(a_num_bound, num_q > NumW'(MAX_CHUNKS), "chunk count beyond table size")
  `ASSERT_PROP(a_scan, (state_q == ffca_pkg::S_SCAN) |-> (NumW'(idx_q) < num_q), "bad scan index")

endmodule

[hw/rtl/first_fit_chunk_allocator.sv]
// First-fit chunk allocator top level; depends on ffca_pkg, ffca_ctrl and ffca_ram.
// A clear goes from IDLE to CLEAR, where its result is offered; an allocation reads the
// chunk entries in turn in SCAN (at most MAX_CHUNKS of them) and ends there on a fit, or
// goes on to DECIDE when a chunk is appended or the request is refused. One request at a
// time: the next is taken once the result of the last has left the sequencer, so requests
// never overlap. Reset empties the chunk table.

module first_fit_chunk_allocator #(
  parameter int unsigned MAX_CHUNKS = 64,
  localparam int unsigned IdxW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
  localparam int unsigned OutDW = ((IdxW + ffca_pkg::CountW + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel: capacity of each newly appended chunk
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ffca_pkg::CountW-1:0]         cfg_data_i,
  // Request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // [9:0] count, rest zero
  input  logic                                s_axis_tuser,  // [0] op
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [OutDW-1:0]                    m_axis_tdata,  // chunk_index, start_offset
  output logic [ffca_pkg::StatusW-1:0]        m_axis_tuser   // [1:0] status
);

  // New-chunk capacity register, 10 after reset, always ready. Writes are to be made only
  // while the block is idle, which the block does not enforce. Existing chunks keep theirs.
  logic [ffca_pkg::CountW-1:0] new_cap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_cap_q <= ffca_pkg::ChunkSizeRst;
    end else if (cfg_valid_i) begin
      new_cap_q <= cfg_data_i;
    end
  end

  // Chunk RAM: one entry per chunk holding its capacity and used count. It is not
  // swept after reset, as entries at or above the chunk count are never used.
  logic              ram_rd_en;
  logic [IdxW-1:0]   ram_rd_addr;
  ffca_pkg::entry_t  ram_rd_data;
  logic              ram_wr_en;
  logic [IdxW-1:0]   ram_wr_addr;
  ffca_pkg::entry_t  ram_wr_data;

  ffca_ram #(
    .WIDTH (ffca_pkg::EntryW),
    .DEPTH (MAX_CHUNKS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Sequencer. The RAM write of an item happens in the cycle its result is handed
  // over, and the next item's first read is issued no earlier than the following
  // cycle, so reads never overlap a pending write to the same entry.
  logic                         res_valid;
  logic                         res_ready;
  ffca_pkg::status_e            res_status;
  logic [IdxW-1:0]              res_idx;
  logic [ffca_pkg::CountW-1:0]  res_off;

  ffca_ctrl #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_op_i      (s_axis_tuser),
    .req_count_i   (s_axis_tdata[ffca_pkg::CountW-1:0]),
    .req_ready_o   (s_axis_tready),
    .new_cap_i     (new_cap_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_status_o  (res_status),
    .res_idx_o     (res_idx),
    .res_off_o     (res_off),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data)
  );

  // Output register. A finished word waits here, so the sequencer can take the
  // next request while the downstream side stalls; it only waits when a second
  // result is ready before the first has been taken.
  logic                         out_valid_q;
  ffca_pkg::status_e            out_status_q;
  logic [IdxW-1:0]              out_idx_q;
  logic [ffca_pkg::CountW-1:0]  out_off_q;

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_status_q <= res_status;
      out_idx_q    <= res_idx;
      out_off_q    <= res_off;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDW'({out_off_q, out_idx_q});
  assign m_axis_tuser  = out_status_q;

endmodule

[tb/tb_first_fit_chunk_allocator.sv]
// Self-checking testbench for first_fit_chunk_allocator: directed and random
// requests, with a grant ledger that predicts every result word.
// Depends on ffca_pkg and the first_fit_chunk_allocator RTL.
`timescale 1ns / 100ps

module tb_first_fit_chunk_allocator;

  localparam int unsigned CountW      = ffca_pkg::CountW;
  localparam int unsigned StatusW     = ffca_pkg::StatusW;
  localparam int unsigned MaxChunks   = 64;
  localparam int unsigned IdxW        = $clog2(MaxChunks);
  localparam int unsigned OutDW       = ((IdxW + CountW + 7) / 8) * 8;
  // A scan reads at most one entry per cycle, so the drain wait covers the slowest word.
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned MaxGap      = 17;
  localparam int unsigned PhaseItems  = 193;
  // The slowest correct run is roughly 2000 words.
  localparam int unsigned CycleLimit  = 1000000;

  // One result word as the block should deliver it.
  typedef struct packed {
    ffca_pkg::status_e status;
    logic [IdxW-1:0]   idx;
    logic [CountW-1:0] offset;
  } grant_t;

  // Keeps its own copy of the chunk table and the new-chunk capacity, works out
  // the grant that each accepted request should produce, and checks the result
  // words against those grants in order.
  class grant_ledger;
    logic [CountW-1:0] size_reg;
    logic [CountW-1:0] taken[MaxChunks];
    logic [CountW-1:0] capacity[MaxChunks];
    int unsigned       n_chunks;
    grant_t            grants_due[$];
    int unsigned       n_wrong;

    function new();
      size_reg = ffca_pkg::ChunkSizeRst;
      n_chunks = 0;
      n_wrong  = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      n_wrong++;
    endtask

    // First fit: the oldest chunk with enough room wins; otherwise a new
    // chunk is appended, unless the request is too large or the table is full.
    function void note_request(logic op, logic [CountW-1:0] cnt);
      grant_t      g;
      int unsigned i;
      bit          hit;
      g   = '{status: ffca_pkg::STAT_OK, idx: '0, offset: '0};
      hit = 1'b0;
      if (op == ffca_pkg::OpClear) begin
        n_chunks = 0;
        g.status = ffca_pkg::STAT_CLEARED;
      end else begin
        for (i = 0; i < n_chunks; i++) begin
          if (!hit && capacity[i] >= taken[i] && capacity[i] - taken[i] >= cnt) begin
            hit      = 1'b1;
            g.idx    = i[IdxW-1:0];
            g.offset = taken[i];
            taken[i] = taken[i] + cnt;
          end
        end
        if (!hit) begin
          if (cnt > size_reg) begin
            g.status = ffca_pkg::STAT_TOO_BIG;
          end else if (n_chunks >= MaxChunks) begin
            g.status = ffca_pkg::STAT_FULL;
          end else begin
            capacity[n_chunks] = size_reg;
            taken[n_chunks]    = cnt;
            g.idx              = n_chunks[IdxW-1:0];
            n_chunks++;
          end
        end
      end
      grants_due.push_back(g);
    endfunction

    task check_grant(logic [StatusW-1:0] status, logic [IdxW-1:0] idx,
                     logic [CountW-1:0] offset);
      grant_t g;
      if (grants_due.size() == 0) begin
        report($sformatf("result word with nothing outstanding: status %0d", status));
        return;
      end
      g = grants_due.pop_front();
      if (status !== g.status)
        report($sformatf("wrong status: got %0d, want %0d", status, g.status));
      if (idx !== g.idx)
        report($sformatf("wrong chunk index: got %0d, want %0d", idx, g.idx));
      if (offset !== g.offset)
        report($sformatf("wrong start offset: got %0d, want %0d", offset, g.offset));
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CountW-1:0]   cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;  // [9:0] count, rest zero
  logic                s_axis_tuser  = 1'b0; // [0] op
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDW-1:0]    m_axis_tdata;        // [5:0] chunk_index, [15:6] start_offset
  logic [StatusW-1:0]  m_axis_tuser;        // [1:0] status

  grant_ledger ledger = new();
  int unsigned cycle_cnt = 0;
  // Idling modes for the current phase: an eager side never pauses, but the long hold still applies.
  bit          tx_eager  = 1'b0;
  bit          rx_eager  = 1'b0;
  // Set by the stimulus to make the result sink hold off for a long stretch.
  bit          hold_off  = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  first_fit_chunk_allocator #(
    .MAX_CHUNKS(MaxChunks)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Offers one request word after a random pause and notes it in the ledger
  // once it has been taken. The valid is left high on return, so that a
  // following word with no pause goes out back to back.
  task automatic send_request(logic op, logic [CountW-1:0] cnt);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(16 - CountW){1'b0}}, cnt};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    ledger.note_request(op, cnt);
  endtask

  // Withdraws the request stream and waits until every grant has come back,
  // then a little longer so that a stray word would still be caught.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (ledger.grants_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // The new-chunk capacity is only changed once the block has gone quiet.
  task automatic set_new_cap(logic [CountW-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    ledger.size_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Random allocation sizes lean on the current chunk capacity, so that chunks
  // fill up, the table runs full and refusals still turn up now and then.
  function automatic logic [CountW-1:0] draw_count(int unsigned size);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return CountW'($urandom_range(0, size));
    if (pick < 72) return CountW'(size);
    if (pick < 82) return CountW'($urandom_range(0, 3));
    if (pick < 90 && size < 1023) return CountW'($urandom_range(size + 1, 1023));
    return CountW'($urandom_range(0, 1023));
  endfunction

  task automatic run_phase(int unsigned size, bit long_hold);
    int unsigned n;
    set_new_cap(CountW'(size));
    tx_eager = ($urandom_range(0, 3) == 0);
    rx_eager = ($urandom_range(0, 3) == 0);
    // The long hold only makes sense if the sender keeps offering words.
    if (long_hold) begin
      tx_eager = 1'b1;
      hold_off = 1'b1;
    end
    for (n = 0; n < PhaseItems; n++) begin
      if ($urandom_range(0, 149) == 0) send_request(ffca_pkg::OpClear, '0);
      else send_request(ffca_pkg::OpAlloc, draw_count(size));
    end
  endtask

  // Result sink: pauses at random before each word and checks what it takes.
  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      gap = rx_eager ? 0 : $urandom_range(0, MaxGap);
      if (hold_off) begin
        gap      = HoldCycles;
        hold_off = 1'b0;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      ledger.check_grant(m_axis_tuser, m_axis_tdata[IdxW-1:0],
                         m_axis_tdata[IdxW +: CountW]);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("first_fit_chunk_allocator: mismatch");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset chunk capacity of ten.
    send_request(ffca_pkg::OpAlloc, 10'd0);    // zero count with no chunks appends one
    send_request(ffca_pkg::OpAlloc, 10'd10);   // exactly fills the first chunk
    send_request(ffca_pkg::OpAlloc, 10'd0);    // zero count fits even a full chunk
    send_request(ffca_pkg::OpAlloc, 10'd1);    // nothing fits, so a second chunk is appended
    send_request(ffca_pkg::OpAlloc, 10'd11);   // one more than the chunk capacity
    send_request(ffca_pkg::OpAlloc, 10'd1023); // largest request
    send_request(ffca_pkg::OpAlloc, 10'd9);    // fills the second chunk from offset one
    send_request(ffca_pkg::OpClear, 10'd0);
    send_request(ffca_pkg::OpAlloc, 10'd3);
    send_request(ffca_pkg::OpAlloc, 10'd7);

    // Largest chunk capacity; the old small chunks keep theirs.
    set_new_cap(10'd1023);
    send_request(ffca_pkg::OpAlloc, 10'd1023);
    send_request(ffca_pkg::OpAlloc, 10'd512);
    send_request(ffca_pkg::OpAlloc, 10'd511);
    send_request(ffca_pkg::OpAlloc, 10'd1);
    send_request(ffca_pkg::OpAlloc, 10'd0);

    // Zero chunk capacity: existing chunks still serve, new ones hold nothing.
    set_new_cap(10'd0);
    send_request(ffca_pkg::OpAlloc, 10'd1);
    send_request(ffca_pkg::OpClear, 10'd0);
    send_request(ffca_pkg::OpAlloc, 10'd1);    // refused as too large
    send_request(ffca_pkg::OpAlloc, 10'd0);    // appends a chunk of capacity zero
    send_request(ffca_pkg::OpAlloc, 10'd0);
    send_request(ffca_pkg::OpAlloc, 10'd682);

    // Random phases over a spread of chunk capacities, the extremes among them.
    run_phase(1, 1'b1);
    run_phase(1023, 1'b0);
    run_phase(0, 1'b0);
    run_phase($urandom_range(2, 15), 1'b0);
    run_phase($urandom_range(16, 1023), 1'b0);
    run_phase(3, 1'b0);
    run_phase(1, 1'b0);
    run_phase($urandom_range(1, 1023), 1'b0);
    run_phase(1023, 1'b0);
    run_phase($urandom_range(2, 40), 1'b0);

    wait_drained();
    if (ledger.n_wrong == 0 && ledger.grants_due.size() == 0) begin
      $display("first_fit_chunk_allocator: match");
    end else begin
      $display("first_fit_chunk_allocator: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_ram.sv
hw/rtl/ffca_ctrl.sv
hw/rtl/first_fit_chunk_allocator.sv
tb/tb_first_fit_chunk_allocator.sv
